### rtl/rlu_pkg.sv
`default_nettype none
package rlu_pkg;

    // Input word: one command for the recency list.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] entry_id;
        logic [4:0] release_amount;
    } t_in_word;

    // Output word: one result of a command.
    typedef struct packed {
        logic [7:0] released_id;
        logic       has_id;
        logic [1:0] status;
        logic [4:0] entry_count;
        logic       last;
    } t_out_word;

    typedef enum logic [2:0] {
        ACT_ATTACH  = 3'd0,
        ACT_TOUCH   = 3'd1,
        ACT_DETACH  = 3'd2,
        ACT_MARK    = 3'd3,
        ACT_RELEASE = 3'd4,
        ACT_CLEAR   = 3'd5,
        ACT_REPORT  = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOCHG    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CK,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_SORT_RD,
        S_SORT_WR,
        S_EV_RD,
        S_EV_OUT,
        S_RP_RD,
        S_RP_OUT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### rtl/rlu_ram.sv
`default_nettype none
// Simple dual-port memory: one write and one registered read per cycle.
module rlu_ram #(
    parameter int W     = 9,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [W-1:0]             i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]            o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/recency_list_with_used_bits.sv
`default_nettype none
// Channel   Direction  Handshake                  Word
// in        input      i_in_valid / o_in_stall    t_in_word  (action, id, release amount)
// out       output     o_out_valid / i_out_stall  t_out_word (id, flags, status, count)
//
// Commands that search, shift, reorder or report walk the list through one registered memory
// read port. A search or a downward shift runs over the held entries, an attach or a touch
// searches and then shifts up, a release reorders the list and then evicts from its back,
// and a report reads each entry. The input is stalled until the command has ended.
// Reset is synchronous and active low; it empties the list but leaves the memory as is.
// A stalled output word holds the sequencer, and the last word may wait into the next command.
module recency_list_with_used_bits
    import rlu_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  t_in_word   i_in_word,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  wire        i_out_stall
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = ID_BITS + 1;

    // Control and datapath registers.
    t_state              r_state, n_state;
    t_action             r_action, n_action;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [4:0]          r_amount, n_amount;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_wr, n_wr;
    logic [CW-1:0]       r_left, n_left;
    logic [CW-1:0]       r_fin, n_fin;
    logic                r_pass, n_pass;
    logic                r_bank, n_bank;
    logic [W-1:0]        r_new, n_new;
    logic                r_grow, n_grow;
    t_status             r_status, n_status;
    t_out_word           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // Memory controls.
    logic                we_live, we_other;
    logic [AW-1:0]       waddr, raddr;
    logic [W-1:0]        wdata;
    logic [W-1:0]        rdata_a, rdata_b, rdata;
    logic                we_a, we_b;

    logic                in_acc, out_free;
    logic [ID_BITS-1:0]  rd_id;
    logic                rd_mark;
    logic [CW-1:0]       idx_p1;
    logic [CW+4:0]       amt_x, cnt_x;
    logic [CW+4:0]       cnt_w, fin_w;
    logic [ID_BITS+7:0]  rd_id_w;
    logic [ID_BITS+7:0]  in_id_w;

    // Two banks: one holds the live list, the other receives the reordered
    // list during a release, after which the roles swap.
    rlu_ram #(.W(W), .DEPTH(DEPTH)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    rlu_ram #(.W(W), .DEPTH(DEPTH)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    assign we_a    = (we_live && !r_bank) || (we_other && r_bank);
    assign we_b    = (we_live && r_bank) || (we_other && !r_bank);
    assign rdata   = r_bank ? rdata_b : rdata_a;
    assign rd_id   = rdata[ID_BITS-1:0];
    assign rd_mark = rdata[ID_BITS];
    assign idx_p1  = r_idx + CW'(1);
    assign rd_id_w = (ID_BITS + 8)'(rd_id);
    assign in_id_w = (ID_BITS + 8)'(i_in_word.entry_id);
    assign amt_x   = (CW + 5)'(r_amount);
    assign cnt_x   = (CW + 5)'(r_count);
    assign cnt_w   = (CW + 5)'(r_count);
    assign fin_w   = (CW + 5)'(r_fin);

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.action) inside
                        ACT_ATTACH, ACT_TOUCH, ACT_DETACH, ACT_MARK: n_state = S_FIND_RD;
                        ACT_RELEASE: n_state = S_SORT_RD;
                        ACT_REPORT:  n_state = (r_count == '0) ? S_DONE : S_RP_RD;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_FIND_RD: begin
                if (r_idx == r_count) begin
                    if (r_action == ACT_ATTACH && r_count != CW'(DEPTH)) begin
                        n_state = S_UP_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_FIND_CK;
                end
            end
            S_FIND_CK: begin
                if (rd_id == r_id) begin
                    case (r_action)
                        ACT_TOUCH:  n_state = S_UP_RD;
                        ACT_DETACH: n_state = S_DN_RD;
                        default:    n_state = S_DONE;
                    endcase
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_UP_RD:   n_state = (r_idx == '0) ? S_DONE : S_UP_WR;
            S_UP_WR:   n_state = S_UP_RD;
            S_DN_RD:   n_state = (idx_p1 >= r_count) ? S_DONE : S_DN_WR;
            S_DN_WR:   n_state = S_DN_RD;
            S_SORT_RD: begin
                if (r_idx == r_count) begin
                    if (r_pass) begin
                        n_state = (r_count == '0 || r_amount == '0) ? S_DONE : S_EV_RD;
                    end
                end else begin
                    n_state = S_SORT_WR;
                end
            end
            S_SORT_WR: n_state = S_SORT_RD;
            S_EV_RD:   n_state = S_EV_OUT;
            S_EV_OUT: begin
                if (out_free) begin
                    n_state = (r_left == CW'(1)) ? S_IDLE : S_EV_RD;
                end
            end
            S_RP_RD:   n_state = S_RP_OUT;
            S_RP_OUT: begin
                if (out_free) begin
                    n_state = (idx_p1 == r_count) ? S_IDLE : S_RP_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and output register.
    always_comb begin
        n_action    = r_action;
        n_id        = r_id;
        n_amount    = r_amount;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_left      = r_left;
        n_fin       = r_fin;
        n_pass      = r_pass;
        n_bank      = r_bank;
        n_new       = r_new;
        n_grow      = r_grow;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        we_live     = 1'b0;
        we_other    = 1'b0;
        waddr       = r_idx[AW-1:0];
        wdata       = rdata;
        raddr       = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_action = t_action'(i_in_word.action);
                    n_id     = in_id_w[ID_BITS-1:0];
                    n_amount = i_in_word.release_amount;
                    n_idx    = '0;
                    n_wr     = '0;
                    n_pass   = 1'b0;
                    case (i_in_word.action)
                        ACT_CLEAR: begin
                            n_count  = '0;
                            n_status = ST_DONE;
                        end
                        default: n_status = ST_NOCHG;
                    endcase
                end
            end
            S_FIND_RD: begin
                if (r_idx == r_count) begin
                    case (r_action)
                        ACT_ATTACH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_new  = {1'b0, r_id};
                                n_grow = 1'b1;
                            end
                        end
                        ACT_DETACH: n_status = ST_NOTFOUND;
                        default:    n_status = ST_NOCHG;
                    endcase
                end
            end
            S_FIND_CK: begin
                if (rd_id == r_id) begin
                    case (r_action)
                        ACT_ATTACH: n_status = ST_NOCHG;
                        ACT_TOUCH: begin
                            n_new  = {rd_mark, r_id};
                            n_grow = 1'b0;
                        end
                        ACT_MARK: begin
                            we_live  = 1'b1;
                            wdata    = {1'b1, r_id};
                            n_status = ST_DONE;
                        end
                        default: ;
                    endcase
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    we_live  = 1'b1;
                    wdata    = r_new;
                    n_status = ST_DONE;
                    if (r_grow) begin
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    raddr = r_idx[AW-1:0] - AW'(1);
                end
            end
            S_UP_WR: begin
                we_live = 1'b1;
                n_idx   = r_idx - CW'(1);
            end
            S_DN_RD: begin
                if (idx_p1 >= r_count) begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_DONE;
                end else begin
                    raddr = idx_p1[AW-1:0];
                end
            end
            S_DN_WR: begin
                we_live = 1'b1;
                n_idx   = idx_p1;
            end
            S_SORT_RD: begin
                if (r_idx == r_count) begin
                    n_idx = '0;
                    if (!r_pass) begin
                        n_pass = 1'b1;
                    end else begin
                        // Reordered list is complete; evict from its back.
                        n_bank = !r_bank;
                        if (amt_x >= cnt_x) begin
                            n_left = r_count;
                        end else begin
                            n_left = CW'(r_amount);
                        end
                        n_fin    = r_count - n_left;
                        n_status = ST_NOCHG;
                    end
                end
            end
            S_SORT_WR: begin
                // Used entries go first, then unused; marks leave cleared.
                if (rd_mark == !r_pass) begin
                    we_other = 1'b1;
                    waddr    = r_wr[AW-1:0];
                    wdata    = {1'b0, rd_id};
                    n_wr     = r_wr + CW'(1);
                end
                n_idx = idx_p1;
            end
            S_EV_RD, S_EV_OUT: begin
                raddr = r_count[AW-1:0] - AW'(1);
                if (r_state == S_EV_OUT && out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.released_id = rd_id_w[7:0];
                    n_out.has_id      = 1'b1;
                    n_out.status      = ST_DONE;
                    n_out.entry_count = fin_w[4:0];
                    n_out.last        = (r_left == CW'(1));
                    n_count           = r_count - CW'(1);
                    n_left            = r_left - CW'(1);
                end
            end
            S_RP_RD, S_RP_OUT: begin
                if (r_state == S_RP_OUT && out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.released_id = rd_id_w[7:0];
                    n_out.has_id      = 1'b1;
                    n_out.status      = ST_DONE;
                    n_out.entry_count = cnt_w[4:0];
                    n_out.last        = (idx_p1 == r_count);
                    n_idx             = idx_p1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.released_id = '0;
                    n_out.has_id      = 1'b0;
                    n_out.status      = r_status;
                    n_out.entry_count = cnt_w[4:0];
                    n_out.last        = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
        end
        r_action <= n_action;
        r_id     <= n_id;
        r_amount <= n_amount;
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_left   <= n_left;
        r_fin    <= n_fin;
        r_pass   <= n_pass;
        r_new    <= n_new;
        r_grow   <= n_grow;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // The list never holds more entries than the memory has rows.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("held count above depth");

    // An eviction always has an entry left to take from the back.
    a_evict_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV_OUT) |-> (r_left != '0 && r_left <= r_count))
        else $error("eviction with no entry left");

    // The reorder write pointer never runs past the held count.
    a_sort_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT_WR) |-> (r_wr <= r_count))
        else $error("reorder write pointer beyond the held count");

endmodule
`default_nettype wire
